// ===== hdl/sgrw_pkg.sv =====
// Shared types, constant tables and microcode program for the gain sequencer.
`default_nettype none
package sgrw_pkg;

  localparam int unsigned GainW      = 14;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LevelW     = 13;
  localparam int unsigned TableRows  = 25;
  localparam int unsigned GainLevels = 25;
  localparam int unsigned SearchRows = (GainLevels < TableRows) ? GainLevels : TableRows;
  localparam int unsigned LvlW       = $clog2(TableRows);
  localparam int unsigned FracBits   = 6;
  localparam int unsigned DividendW  = GainW + FracBits;
  localparam int unsigned BitsPerCyc = 2;
  localparam int unsigned DivCycles  = DividendW / BitsPerCyc;
  localparam int unsigned DivCntW    = $clog2(DivCycles);
  localparam int unsigned PcW        = 4;
  localparam int unsigned StageIdxW  = 3;

  // step numbers of the program
  localparam logic [PcW-1:0] StIdle   = 4'd0;
  localparam logic [PcW-1:0] StSearch = 4'd1;
  localparam logic [PcW-1:0] StDiv    = 4'd2;
  localparam logic [PcW-1:0] StWr0    = 4'd3;
  localparam logic [PcW-1:0] StWr1    = 4'd4;
  localparam logic [PcW-1:0] StWr2    = 4'd5;
  localparam logic [PcW-1:0] StWr3    = 4'd6;
  localparam logic [PcW-1:0] StWr4    = 4'd7;
  localparam logic [PcW-1:0] StWr5    = 4'd8;
  localparam logic [PcW-1:0] StWr6    = 4'd9;
  localparam logic [PcW-1:0] StWr7    = 4'd10;
  localparam logic [PcW-1:0] StWr8    = 4'd11;
  localparam logic [PcW-1:0] StWr9    = 4'd12;
  localparam logic [PcW-1:0] StWr10   = 4'd13;
  localparam logic [PcW-1:0] StNoChg  = 4'd14;

  localparam logic [AddrW-1:0] RegAgc0   = 16'h00b3;
  localparam logic [AddrW-1:0] RegAgc1   = 16'h00b8;
  localparam logic [AddrW-1:0] RegAgc2   = 16'h00b9;
  localparam logic [AddrW-1:0] RegAgc3   = 16'h0155;
  localparam logic [AddrW-1:0] RegCtl    = 16'h031d;
  localparam logic [AddrW-1:0] RegAgc4   = 16'h00c2;
  localparam logic [AddrW-1:0] RegAgc5   = 16'h00cf;
  localparam logic [AddrW-1:0] RegAgc6   = 16'h00d9;
  localparam logic [AddrW-1:0] RegDgHi   = 16'h00b1;
  localparam logic [AddrW-1:0] RegDgLo   = 16'h00b2;
  localparam logic [ByteW-1:0] CtlOpen   = 8'h2d;
  localparam logic [ByteW-1:0] CtlClose  = 8'h28;

  typedef enum logic [1:0] {
    OP_WAIT_IN,
    OP_SEARCH,
    OP_DIV,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_ALWAYS,
    J_SAME,
    J_DIV_MORE
  } jmp_e;

  typedef enum logic [2:0] {
    DS_ZERO,
    DS_STAGE,
    DS_CONST,
    DS_DG_HI,
    DS_DG_LO
  } dsel_e;

  typedef struct packed {
    op_e                  op;
    jmp_e                 jmp;
    logic [PcW-1:0]       target;
    logic                 wr;
    logic                 last;
    logic [AddrW-1:0]     addr;
    dsel_e                dsel;
    logic [StageIdxW-1:0] stage;
    logic [ByteW-1:0]     cdata;
  } ctl_t;

  typedef struct packed {
    logic same;
    logic div_more;
  } stat_t;

  typedef struct packed {
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic [GainW-1:0] gain;
    logic             last;
  } item_t;

  typedef logic [6:0][ByteW-1:0] stage_row_t;

  function automatic ctl_t mk_emit(input logic [AddrW-1:0] addr, input dsel_e dsel,
                                   input logic [StageIdxW-1:0] stage,
                                   input logic [ByteW-1:0] cdata);
    ctl_t c;
    c        = '0;
    c.op     = OP_EMIT;
    c.jmp    = J_NONE;
    c.target = StIdle;
    c.wr     = 1'b1;
    c.addr   = addr;
    c.dsel   = dsel;
    c.stage  = stage;
    c.cdata  = cdata;
    return c;
  endfunction

  function automatic ctl_t ucode(input logic [PcW-1:0] pc);
    ctl_t c;
    c = '0;
    case (pc)
      StIdle: begin
        c.op  = OP_WAIT_IN;
        c.jmp = J_NONE;
      end
      StSearch: begin
        c.op     = OP_SEARCH;
        c.jmp    = J_SAME;
        c.target = StNoChg;
      end
      StDiv: begin
        c.op     = OP_DIV;
        c.jmp    = J_DIV_MORE;
        c.target = StDiv;
      end
      StWr0:  c = mk_emit(RegAgc0, DS_STAGE, 3'd0, '0);
      StWr1:  c = mk_emit(RegAgc1, DS_STAGE, 3'd1, '0);
      StWr2:  c = mk_emit(RegAgc2, DS_STAGE, 3'd2, '0);
      StWr3:  c = mk_emit(RegAgc3, DS_STAGE, 3'd3, '0);
      StWr4:  c = mk_emit(RegCtl, DS_CONST, 3'd0, CtlOpen);
      StWr5:  c = mk_emit(RegAgc4, DS_STAGE, 3'd4, '0);
      StWr6:  c = mk_emit(RegAgc5, DS_STAGE, 3'd5, '0);
      StWr7:  c = mk_emit(RegAgc6, DS_STAGE, 3'd6, '0);
      StWr8:  c = mk_emit(RegCtl, DS_CONST, 3'd0, CtlClose);
      StWr9:  c = mk_emit(RegDgHi, DS_DG_HI, 3'd0, '0);
      StWr10: begin
        c        = mk_emit(RegDgLo, DS_DG_LO, 3'd0, '0);
        c.last   = 1'b1;
        c.jmp    = J_ALWAYS;
        c.target = StIdle;
      end
      StNoChg: begin
        c        = mk_emit('0, DS_ZERO, 3'd0, '0);
        c.wr     = 1'b0;
        c.last   = 1'b1;
        c.jmp    = J_ALWAYS;
        c.target = StIdle;
      end
      default: begin
        c.op     = OP_WAIT_IN;
        c.jmp    = J_ALWAYS;
        c.target = StIdle;
      end
    endcase
    return c;
  endfunction

  function automatic logic [LevelW-1:0] level_q6(input logic [LvlW-1:0] idx);
    logic [LevelW-1:0] v;
    case (idx)
      5'd0:    v = 13'd64;
      5'd1:    v = 13'd76;
      5'd2:    v = 13'd91;
      5'd3:    v = 13'd107;
      5'd4:    v = 13'd125;
      5'd5:    v = 13'd147;
      5'd6:    v = 13'd177;
      5'd7:    v = 13'd211;
      5'd8:    v = 13'd248;
      5'd9:    v = 13'd297;
      5'd10:   v = 13'd356;
      5'd11:   v = 13'd425;
      5'd12:   v = 13'd504;
      5'd13:   v = 13'd599;
      5'd14:   v = 13'd709;
      5'd15:   v = 13'd836;
      5'd16:   v = 13'd978;
      5'd17:   v = 13'd1153;
      5'd18:   v = 13'd1647;
      5'd19:   v = 13'd1651;
      5'd20:   v = 13'd1935;
      5'd21:   v = 13'd2292;
      5'd22:   v = 13'd3239;
      5'd23:   v = 13'd3959;
      5'd24:   v = 13'd4686;
      default: v = 13'd64;
    endcase
    return v;
  endfunction

  // byte 0 of a row sits in element 6
  function automatic stage_row_t stage_row(input logic [LvlW-1:0] idx);
    stage_row_t r;
    case (idx)
      5'd0:    r = 56'h00_01_00_08_10_08_0a;
      5'd1:    r = 56'h10_01_0c_08_10_08_0a;
      5'd2:    r = 56'h20_01_1b_08_10_08_0a;
      5'd3:    r = 56'h30_01_2c_08_11_08_0c;
      5'd4:    r = 56'h40_01_3f_08_12_08_0e;
      5'd5:    r = 56'h50_02_16_08_14_08_12;
      5'd6:    r = 56'h60_02_35_08_15_08_14;
      5'd7:    r = 56'h70_03_16_08_17_08_18;
      5'd8:    r = 56'h80_04_02_08_18_08_1a;
      5'd9:    r = 56'h90_04_31_08_19_08_1c;
      5'd10:   r = 56'ha0_05_32_08_1b_08_20;
      5'd11:   r = 56'hb0_06_35_08_1c_08_22;
      5'd12:   r = 56'hc0_08_04_08_1e_08_26;
      5'd13:   r = 56'h5a_09_19_08_1c_08_26;
      5'd14:   r = 56'h83_0b_0f_08_1c_08_26;
      5'd15:   r = 56'h93_0d_12_08_1f_08_28;
      5'd16:   r = 56'h84_10_00_0b_20_08_2a;
      5'd17:   r = 56'h94_12_3a_0b_22_08_2e;
      5'd18:   r = 56'h5d_1a_02_0b_27_08_38;
      5'd19:   r = 56'h9b_1b_20_0b_28_08_3a;
      5'd20:   r = 56'h8c_20_0f_0b_2a_08_3e;
      5'd21:   r = 56'h9c_26_07_12_2d_08_44;
      5'd22:   r = 56'hb6_36_21_12_2d_08_44;
      5'd23:   r = 56'had_37_3a_12_2d_08_44;
      5'd24:   r = 56'hbd_3d_02_12_2d_08_44;
      default: r = 56'h00_01_00_08_10_08_0a;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sgrw_seq.sv =====
// Microcode sequencer: step counter, program ROM and conditional jumps.
`default_nettype none
module sgrw_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           out_free_i,
  input  wire sgrw_pkg::stat_t stat_i,
  output sgrw_pkg::ctl_t      ctl_o,
  output logic                fire_o,
  output logic                in_ready_o
);
  import sgrw_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ctl_t           ctl;
  logic           take;

  assign ctl = ucode(pc_q);

  always_comb begin
    case (ctl.op)
      OP_WAIT_IN: fire_o = in_valid_i;
      OP_EMIT:    fire_o = out_free_i;
      default:    fire_o = 1'b1;
    endcase
  end

  always_comb begin
    case (ctl.jmp)
      J_ALWAYS:   take = 1'b1;
      J_SAME:     take = stat_i.same;
      J_DIV_MORE: take = stat_i.div_more;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fire_o) begin
      pc_d = take ? ctl.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o      = ctl;
  assign in_ready_o = (ctl.op == OP_WAIT_IN);

endmodule
`default_nettype wire

// ===== hdl/sgrw_datapath.sv =====
// Datapath: gain cache, level search, two-bit-per-cycle divider and write formatting.
`default_nettype none
module sgrw_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sgrw_pkg::ctl_t               ctl_i,
  input  wire logic                         fire_i,
  input  wire logic [sgrw_pkg::GainW-1:0]   gain_i,
  output sgrw_pkg::stat_t                   stat_o,
  output sgrw_pkg::item_t                   item_o
);
  import sgrw_pkg::*;

  logic [GainW-1:0]     gain_q;
  logic [GainW-1:0]     cached_q;
  logic [LvlW-1:0]      lvl_q, lvl_d;
  logic [LevelW-1:0]    dvs_q, dvs_d;
  logic [LevelW-1:0]    rem_q, rem_d;
  logic [DividendW-1:0] quot_q, quot_d;
  logic [DivCntW-1:0]   cnt_q;
  stage_row_t           row;
  logic [ByteW-1:0]     data;

  // highest threshold not above the request; below the first one stays at row 0
  always_comb begin
    lvl_d = '0;
    dvs_d = level_q6('0);
    for (int i = 0; i < SearchRows; i++) begin
      if ({1'b0, level_q6(LvlW'(i))} <= gain_q) begin
        lvl_d = LvlW'(i);
        dvs_d = level_q6(LvlW'(i));
      end
    end
  end

  // restoring division, two quotient bits per cycle
  always_comb begin
    logic [LevelW:0]      r;
    logic                 ge;
    logic [LevelW-1:0]    rm;
    logic [DividendW-1:0] q;
    rm = rem_q;
    q  = quot_q;
    for (int s = 0; s < BitsPerCyc; s++) begin
      r  = {rm, q[DividendW-1]};
      ge = (r >= {1'b0, dvs_q});
      rm = ge ? LevelW'(r - {1'b0, dvs_q}) : r[LevelW-1:0];
      q  = {q[DividendW-2:0], ge};
    end
    rem_d  = rm;
    quot_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      case (ctl_i.op)
        OP_WAIT_IN: gain_q <= gain_i;
        OP_SEARCH: begin
          lvl_q  <= lvl_d;
          dvs_q  <= dvs_d;
          rem_q  <= '0;
          quot_q <= {gain_q, FracBits'(0)};
        end
        OP_DIV: begin
          rem_q  <= rem_d;
          quot_q <= quot_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_q <= '0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      if (ctl_i.op == OP_SEARCH) begin
        cached_q <= gain_q;
        cnt_q    <= '0;
      end else if (ctl_i.op == OP_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign stat_o.same     = (gain_q == cached_q);
  assign stat_o.div_more = (cnt_q != DivCntW'(DivCycles - 1));

  assign row = stage_row(lvl_q);

  always_comb begin
    case (ctl_i.dsel)
      DS_STAGE: data = row[3'd6 - ctl_i.stage];
      DS_CONST: data = ctl_i.cdata;
      DS_DG_HI: data = quot_q[FracBits+ByteW-1:FracBits];
      DS_DG_LO: data = {quot_q[FracBits-1:0], 2'b00};
      default:  data = '0;
    endcase
  end

  // after the item the cache holds the request either way
  assign item_o.wr   = ctl_i.wr;
  assign item_o.addr = ctl_i.addr;
  assign item_o.data = data;
  assign item_o.gain = gain_q;
  assign item_o.last = ctl_i.last;

endmodule
`default_nettype wire

// ===== hdl/sensor_gain_to_register_writes.sv =====
// Top level: turns a requested sensor gain into a run of register writes.
//
// Slave stream: one transfer carries a requested total gain in Q6.
// Master stream: per request either one item with tuser low (gain unchanged)
// or eleven register writes with tuser high; tlast marks the final item.
// Every item reports the gain now applied.
// A request is taken only while the sequencer idles at its first step, so
// one request is in flight at a time.
// Changed gain: one search step, ten divider steps (two quotient bits each),
// then one write per cycle while the output register is free.
// Unchanged gain: the search step jumps to a single no-change step.
// The output register holds an item while tready is low and the sequencer
// waits on that step; nothing is dropped.
// Reset clears the step counter, the output valid and the cached gain (0).
`default_nettype none
module sensor_gain_to_register_writes (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [13:0] gain_q6
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [15:0] reg_addr, [23:16] reg_data,
                                          // [37:24] applied_gain_q6
  output logic             m_axis_tuser,  // write_valid
  output logic             m_axis_tlast   // last
);
  import sgrw_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  item_t item;
  item_t out_q;
  logic  fire;
  logic  out_free;
  logic  load;
  logic  vld_q;

  assign out_free = !vld_q || m_axis_tready;
  assign load     = fire && (ctl.op == OP_EMIT);

  sgrw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .fire_o     (fire),
    .in_ready_o (s_axis_tready)
  );

  sgrw_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .fire_i (fire),
    .gain_i (s_axis_tdata[GainW-1:0]),
    .stat_o (stat),
    .item_o (item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, out_q.gain, out_q.data, out_q.addr};
  assign m_axis_tuser  = out_q.wr;
  assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire
